### rtl/vlbr_pkg.sv
// Shared constants and helpers for the variable-length bit repacker.
`default_nettype none
package vlbr_pkg;
	localparam int VAL_W = 31;
	localparam int CW_W = 5;
	localparam int CNT_W = $clog2(VAL_W + 1);
	localparam int GRP_W = 8;
	localparam int GRP_N = (VAL_W + GRP_W - 1) / GRP_W;
	localparam int LZG_W = 4;
	localparam logic [CW_W-1:0] CW_RESET = CW_W'(8);

	// leading zeros of one byte, GRP_W when all zero
	function automatic logic [LZG_W-1:0] lz_byte(input logic [GRP_W-1:0] b);
		logic [LZG_W-1:0] n;
		logic hit;
		n = LZG_W'(GRP_W);
		hit = 1'b0;
		for (int i = GRP_W - 1; i >= 0; i--) begin
			if (!hit && b[i]) begin
				n = LZG_W'(GRP_W - 1 - i);
				hit = 1'b1;
			end
		end
		return n;
	endfunction
endpackage
`default_nettype wire

### rtl/vlbr_in_if.sv
// Input channel: one number per beat.
`default_nettype none
interface vlbr_in_if;
	logic valid;
	logic ready;
	logic [vlbr_pkg::VAL_W-1:0] value;
	logic final_number;

	modport source (output valid, value, final_number, input ready);
	modport sink (input valid, value, final_number, output ready);
endinterface
`default_nettype wire

### rtl/vlbr_out_if.sv
// Output channel: one chunk per beat.
`default_nettype none
interface vlbr_out_if;
	logic valid;
	logic ready;
	logic [vlbr_pkg::VAL_W-1:0] chunk;
	logic chunk_last;

	modport source (output valid, chunk, chunk_last, input ready);
	modport sink (input valid, chunk, chunk_last, output ready);
endinterface
`default_nettype wire

### rtl/variable_length_bit_repacker.sv
// Top level: variable-length bit repacker with a shared barrel shifter.
`default_nettype none
// Appends the significant bits of each number, MSB first, to a bit stream and
// emits a chunk of chunk_width bits (0 acts as 1) each time enough bits are
// pending; the last chunk caused by a number carries chunk_last. A number
// marked final_number drops any leftover bits afterwards. One number is taken
// at a time: after the accept, the LZC and NORM states find its leading zeros
// and align it, then each RUN step, unless the output stalls, moves up to one
// chunk's worth of bits through a single 62-bit shifter, and a closing RUN step
// returns to idle. The user must write chunk_width only while idle; the block
// itself does not enforce it.
module variable_length_bit_repacker (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic [vlbr_pkg::CW_W-1:0] cfg_wdata,
	vlbr_in_if.sink items,
	vlbr_out_if.source chunks
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LZC  = 2'd1;
	localparam logic [1:0] ST_NORM = 2'd2;
	localparam logic [1:0] ST_RUN  = 2'd3;
	localparam int VW = vlbr_pkg::VAL_W;
	localparam int CN = vlbr_pkg::CNT_W;

	logic [1:0] state_q;
	logic [vlbr_pkg::CW_W-1:0] cw_q;
	logic [VW-1:0] val_q;
	logic fin_q;
	logic [CN-1:0] nbits_q;
	logic [VW-1:0] pend_q;
	logic [CN-1:0] pcnt_q;
	logic [vlbr_pkg::LZG_W-1:0] lzg_q [vlbr_pkg::GRP_N];
	logic [vlbr_pkg::GRP_N-1:0] nz_q;
	logic out_valid_q;
	logic [VW-1:0] out_chunk_q;
	logic out_last_q;

	logic [CN-1:0] w_eff;
	logic [CN-1:0] need;
	logic [CN-1:0] take;
	logic [CN-1:0] rem;
	logic emit;
	logic go;
	logic push;
	logic [CN-1:0] lz;
	logic [2*VW-1:0] sh_in;
	logic [CN-1:0] sh_amt;
	logic [2*VW-1:0] sh_out;
	logic [vlbr_pkg::GRP_N*vlbr_pkg::GRP_W-1:0] padded;

	assign items.ready = (state_q == ST_IDLE);
	assign chunks.valid = out_valid_q;
	assign chunks.chunk = out_chunk_q;
	assign chunks.chunk_last = out_last_q;

	assign go = !out_valid_q || chunks.ready;
	assign w_eff = (cw_q == '0) ? CN'(1) : CN'(cw_q);
	assign need = (pcnt_q >= w_eff) ? CN'(1) : CN'(w_eff - pcnt_q);
	assign take = (nbits_q < need) ? nbits_q : need;
	assign rem = CN'(nbits_q - take);
	assign emit = (nbits_q != '0) && (take == need);
	assign push = (state_q == ST_RUN) && go && emit;
	assign padded = {val_q, {(vlbr_pkg::GRP_N*vlbr_pkg::GRP_W-VW){1'b0}}};

	always_comb begin
		logic hit;
		lz = '0;
		hit = 1'b0;
		for (int g = 0; g < vlbr_pkg::GRP_N; g++) begin
			if (!hit && nz_q[g]) begin
				lz = CN'(g * vlbr_pkg::GRP_W) + CN'(lzg_q[g]);
				hit = 1'b1;
			end
		end
	end

	// shared shifter: aligns the number, then moves bits into the pending word
	always_comb begin
		if (state_q == ST_NORM) begin
			sh_in = {{VW{1'b0}}, val_q};
			sh_amt = lz;
		end else begin
			sh_in = {pend_q, val_q};
			sh_amt = take;
		end
		sh_out = sh_in << sh_amt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cw_q <= vlbr_pkg::CW_RESET;
		end else if (cfg_we) begin
			cw_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LZC) begin
			for (int g = 0; g < vlbr_pkg::GRP_N; g++) begin
				lzg_q[g] <= vlbr_pkg::lz_byte(
					padded[(vlbr_pkg::GRP_N-g)*vlbr_pkg::GRP_W-1 -: vlbr_pkg::GRP_W]);
				nz_q[g] <= |padded[(vlbr_pkg::GRP_N-g)*vlbr_pkg::GRP_W-1 -:
					vlbr_pkg::GRP_W];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pend_q <= '0;
			pcnt_q <= '0;
			out_valid_q <= 1'b0;
			val_q <= '0;
			fin_q <= 1'b0;
			nbits_q <= '0;
			out_chunk_q <= '0;
			out_last_q <= 1'b0;
		end else begin
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (chunks.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (items.valid) begin
						val_q <= items.value;
						fin_q <= items.final_number;
						state_q <= ST_LZC;
					end
				end
				ST_LZC: begin
					state_q <= ST_NORM;
				end
				ST_NORM: begin
					val_q <= sh_out[VW-1:0];
					nbits_q <= (nz_q != '0) ? CN'(VW - int'(lz)) : '0;
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (go) begin
						if (nbits_q == '0) begin
							if (fin_q) begin
								pend_q <= '0;
								pcnt_q <= '0;
							end
							state_q <= ST_IDLE;
						end else begin
							val_q <= sh_out[VW-1:0];
							nbits_q <= rem;
							if (emit) begin
								out_chunk_q <= sh_out[2*VW-1:VW];
								out_last_q <= (rem < w_eff);
								pend_q <= '0;
								pcnt_q <= '0;
							end else begin
								pend_q <= sh_out[2*VW-1:VW];
								pcnt_q <= CN'(pcnt_q + take);
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

### tb/sv/tb_variable_length_bit_repacker.sv
// Self-checking testbench for the variable-length bit repacker: directed and random traffic, scoreboard.
`default_nettype none
module tb_variable_length_bit_repacker;
	localparam int LIMIT = 400000;
	localparam int SETTLE = 100;
	localparam int MAX_CHUNKS = 31;

	typedef struct {
		logic [vlbr_pkg::VAL_W-1:0] value;
		logic fin;
		bit hold;
	} number_t;

	typedef struct {
		logic [vlbr_pkg::VAL_W-1:0] chunk;
		logic last;
	} chunk_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [vlbr_pkg::CW_W-1:0] cfg_wdata;

	vlbr_in_if items ();
	vlbr_out_if chunks ();

	variable_length_bit_repacker uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.items(items),
		.chunks(chunks)
	);

	number_t pending_numbers[$];
	chunk_t expected_chunks[$];
	logic [vlbr_pkg::CW_W-1:0] width_setting;
	logic [vlbr_pkg::VAL_W-1:0] acc_bits;
	int acc_count;
	int pushed;
	int accepted;
	int errors;
	int cycles;
	int send_idle_pct;
	int recv_stall_pct;
	logic in_fire;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic report(input string msg);
		$display("mismatch @%0d: %s", cycles, msg);
		errors++;
	endtask

	// stream packer: appends significant bits, emits full chunks
	function automatic void pack_number(input logic [vlbr_pkg::VAL_W-1:0] v,
			input logic fin);
		chunk_t made[$];
		chunk_t c;
		int w;
		int top;
		w = (width_setting == '0) ? 1 : int'(width_setting);
		top = -1;
		for (int i = 0; i < vlbr_pkg::VAL_W; i++)
			if (v[i])
				top = i;
		for (int i = top; i >= 0; i--) begin
			acc_bits = {acc_bits[vlbr_pkg::VAL_W-2:0], v[i]};
			acc_count++;
			if (acc_count >= w) begin
				if (made.size() < MAX_CHUNKS) begin
					c.chunk = acc_bits;
					c.last = 1'b0;
					made.push_back(c);
				end
				acc_bits = '0;
				acc_count = 0;
			end
		end
		foreach (made[k]) begin
			c = made[k];
			c.last = (k == made.size() - 1);
			expected_chunks.push_back(c);
		end
		if (fin) begin
			acc_bits = '0;
			acc_count = 0;
		end
	endfunction

	always @(posedge clk) begin : monitor
		chunk_t exp_c;
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			if (chunks.valid && chunks.ready) begin
				if (expected_chunks.size() == 0) begin
					report($sformatf("unexpected chunk %h last %b", chunks.chunk,
						chunks.chunk_last));
				end else begin
					exp_c = expected_chunks.pop_front();
					if (chunks.chunk !== exp_c.chunk)
						report($sformatf("chunk %h, want %h", chunks.chunk, exp_c.chunk));
					if (chunks.chunk_last !== exp_c.last)
						report($sformatf("chunk_last %b, want %b", chunks.chunk_last,
							exp_c.last));
				end
			end
			if (items.valid && items.ready) begin
				pack_number(items.value, items.final_number);
				accepted++;
			end
			in_fire <= items.valid && items.ready;
		end
	end

	always @(negedge clk) begin : driver
		number_t it;
		logic nv;
		if (arst_n && (!items.valid || in_fire)) begin
			nv = 1'b0;
			if (pending_numbers.size() > 0 && $urandom_range(0, 99) >= send_idle_pct &&
					!(pending_numbers[0].hold && expected_chunks.size() != 0)) begin
				it = pending_numbers.pop_front();
				nv = 1'b1;
				items.value <= it.value;
				items.final_number <= it.fin;
			end
			items.valid <= nv;
		end
	end

	always @(negedge clk)
		chunks.ready <= ($urandom_range(0, 99) >= recv_stall_pct);

	task automatic add_number(input logic [vlbr_pkg::VAL_W-1:0] v, input logic fin,
			input bit hold = 0);
		number_t it;
		it.value = v;
		it.fin = fin;
		it.hold = hold;
		pending_numbers.push_back(it);
		pushed++;
	endtask

	task automatic drain();
		while (!(accepted == pushed && expected_chunks.size() == 0))
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_width(input logic [vlbr_pkg::CW_W-1:0] w);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= w;
		width_setting = w;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [vlbr_pkg::VAL_W-1:0] random_number();
		int len;
		logic [31:0] r;
		len = $urandom_range(0, vlbr_pkg::VAL_W);
		if (len == 0)
			return '0;
		r = ($urandom() | (32'd1 << (len - 1))) & (32'hFFFF_FFFF >> (32 - len));
		return r[vlbr_pkg::VAL_W-1:0];
	endfunction

	task automatic set_idling(input int mode);
		case (mode % 4)
			0: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			1: begin
				send_idle_pct = 50;
				recv_stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				recv_stall_pct = 50;
			end
			default: begin
				send_idle_pct = 16;
				recv_stall_pct = 16;
			end
		endcase
	endtask

	initial begin : stimulus
		logic [vlbr_pkg::CW_W-1:0] widths[8];
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		items.valid = 1'b0;
		items.value = '0;
		items.final_number = 1'b0;
		chunks.ready = 1'b0;
		in_fire = 1'b0;
		width_setting = vlbr_pkg::CW_RESET;
		acc_bits = '0;
		acc_count = 0;
		pushed = 0;
		accepted = 0;
		errors = 0;
		cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed, reset width
		add_number('0, 1'b0);
		add_number({vlbr_pkg::VAL_W{1'b1}}, 1'b0);
		add_number(31'h1, 1'b0);
		add_number(31'hAB, 1'b1);
		add_number(31'h5, 1'b1);
		add_number(31'h3, 1'b0);
		add_number('0, 1'b1);
		add_number(31'h2AAA_AAAA, 1'b0);
		add_number(31'h5555_5555, 1'b0, 1);
		add_number(31'h4000_0000, 1'b1);
		drain();

		// width shrinks below what is already pending
		write_width(5'd31);
		add_number(31'h3FFF_FFFF, 1'b0);
		drain();
		write_width(5'd4);
		add_number(31'h1, 1'b0);
		add_number(31'hF, 1'b1);
		drain();
		write_width(5'd0);
		add_number(31'h5, 1'b1);
		add_number(31'h6, 1'b0);
		drain();

		widths = '{5'd1, 5'd31, 5'd0, 5'd3, 5'd5, 5'd13, 5'd16, 5'd7};
		for (int p = 0; p < 8; p++) begin
			set_idling(p);
			write_width((p == 7) ? 5'($urandom_range(1, 31)) : widths[p]);
			for (int n = 0; n < 12; n++)
				add_number(random_number(), ($urandom_range(0, 4) == 0),
					($urandom_range(0, 19) == 0));
			drain();
		end

		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
`default_nettype wire
